// ===== rtl/mdp_pkg.sv =====
// Shared widths, defaults and handshake structs for the modular dot product core.
package mdp_pkg;

  localparam int ELEM_W        = 26;   // input element port width
  localparam int MOD_W         = 26;   // modulus register width
  localparam int BS_W          = 11;   // block size register width
  localparam int OUT_W         = 26;   // result width
  localparam int ACC_W         = 64;   // running sum width
  localparam int MAX_BLOCK_DEF = 1024;
  localparam int ELEM_BITS_DEF = 26;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
  localparam int RED_CNT_W     = $clog2(ACC_W);

  // start a remainder pass over a 64-bit value
  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] value;
  } red_req_t;

  // remainder unit status; rem is valid in the cycle done is high
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MOD_W-1:0] rem;
  } red_rsp_t;

endpackage

// ===== rtl/mdp_front.sv =====
// Front end: takes input requests, masks elements and registers their product.
module mdp_front import mdp_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ELEM_W-1:0]      in_elem_a,
  input  logic [ELEM_W-1:0]      in_elem_b,
  input  logic                   in_last_pair,
  output logic                   push_valid,
  input  logic                   push_ready,
  output logic [2*ELEM_BITS:0]   push_data
);

  localparam int PW = 2 * ELEM_BITS;

  logic              valid_r, valid_nxt;
  logic [PW-1:0]     prod_r, prod_nxt;
  logic              last_r, last_nxt;
  logic [PW-1:0]     a_ext, b_ext;
  logic              take;

  assign a_ext = PW'(in_elem_a[ELEM_BITS-1:0]);
  assign b_ext = PW'(in_elem_b[ELEM_BITS-1:0]);

  // stage moves whenever it is empty or its product goes into the queue
  assign in_ready   = !valid_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = valid_r;
  assign push_data  = {last_r, prod_r};

  always_comb begin
    valid_nxt = valid_r;
    prod_nxt  = prod_r;
    last_nxt  = last_r;
    if (take) begin
      valid_nxt = 1'b1;
      prod_nxt  = a_ext * b_ext;
      last_nxt  = in_last_pair;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    last_r <= last_nxt;
  end

endmodule

// ===== rtl/mdp_fifo.sv =====
// Short queue between the front end and the accumulate back end.
module mdp_fifo import mdp_pkg::*; #(
  parameter int W = 2 * ELEM_BITS_DEF + 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0]       mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               push, pop;

  assign push_ready = (count_r != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? FIFO_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? FIFO_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/mdp_reduce.sv =====
// Bit-serial remainder unit: 64-bit value modulo a 26-bit modulus, one bit per cycle.
module mdp_reduce import mdp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [MOD_W-1:0] modulus,
  input  red_req_t         req,
  output red_rsp_t         rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [ACC_W-1:0]     val_r, val_nxt;
  logic [MOD_W-1:0]     rem_r, rem_nxt;
  logic [RED_CNT_W-1:0] step_r, step_nxt;
  logic [MOD_W:0]       trial, diff;
  logic                 ge;

  // shift in the next dividend bit, subtract once if it reaches the modulus
  assign trial = {rem_r, val_r[ACC_W-1]};
  assign ge    = (trial >= {1'b0, modulus});
  assign diff  = trial - {1'b0, modulus};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      val_nxt  = req.value;
      rem_nxt  = '0;
      step_nxt = '0;
    end else if (busy_r) begin
      val_nxt  = {val_r[ACC_W-2:0], 1'b0};
      rem_nxt  = ge ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == RED_CNT_W'(ACC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/mdp_back.sv =====
// Back end: accumulates products, counts blocks, sequences reductions, holds the result.
module mdp_back import mdp_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF,
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  logic [2*ELEM_BITS:0] pop_data,
  input  logic [MOD_W-1:0]     modulus,
  input  logic [BS_W-1:0]      block_size,
  output red_req_t             red_req,
  input  red_rsp_t             red_rsp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     out_dot_mod
);

  localparam int PW    = 2 * ELEM_BITS;
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int CMP_W = (CNT_W > BS_W) ? CNT_W : BS_W;

  localparam logic [1:0] S_RUN = 2'd0;  // taking products from the queue
  localparam logic [1:0] S_RED = 2'd1;  // remainder pass in flight
  localparam logic [1:0] S_OUT = 2'd2;  // final sum waits for the output slot

  logic [1:0]       state_r, state_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             final_r, final_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_dot_mod_r, out_dot_mod_nxt;
  logic [ACC_W-1:0] acc_sum;
  logic [CNT_W:0]   cnt_inc;
  logic [CNT_W-1:0] eff;
  logic [CMP_W-1:0] bs_ext;
  logic             pop, last, boundary, mod_zero, out_free;

  // block size 0 acts as 1, above MAX_BLOCK saturates
  assign bs_ext = CMP_W'(block_size);
  always_comb begin
    if (block_size == '0) begin
      eff = CNT_W'(1);
    end else if (bs_ext > CMP_W'(MAX_BLOCK)) begin
      eff = CNT_W'(MAX_BLOCK);
    end else begin
      eff = CNT_W'(bs_ext);
    end
  end

  assign pop       = (state_r == S_RUN) && pop_valid;
  assign pop_ready = (state_r == S_RUN);
  assign last      = pop_data[PW];
  assign acc_sum   = acc_r + ACC_W'(pop_data[PW-1:0]);
  assign cnt_inc   = {1'b0, count_r} + 1'b1;
  assign boundary  = (cnt_inc >= {1'b0, eff});
  assign mod_zero  = (modulus == '0);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt       = state_r;
    acc_nxt         = acc_r;
    count_nxt       = count_r;
    final_nxt       = final_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_dot_mod_nxt = out_dot_mod_r;
    red_req.start   = 1'b0;
    red_req.value   = acc_sum;
    unique case (state_r)
      S_RUN: begin
        if (pop) begin
          acc_nxt = acc_sum;
          if (last) begin
            count_nxt = '0;
            final_nxt = 1'b1;
            if (mod_zero) begin
              state_nxt = S_OUT;
            end else begin
              red_req.start = 1'b1;
              state_nxt     = S_RED;
            end
          end else if (boundary) begin
            count_nxt = '0;
            if (!mod_zero) begin
              red_req.start = 1'b1;
              final_nxt     = 1'b0;
              state_nxt     = S_RED;
            end
          end else begin
            count_nxt = cnt_inc[CNT_W-1:0];
          end
        end
      end
      S_RED: begin
        if (red_rsp.done) begin
          acc_nxt   = ACC_W'(red_rsp.rem);
          state_nxt = final_r ? S_OUT : S_RUN;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_dot_mod_nxt = acc_r[OUT_W-1:0];
          acc_nxt         = '0;
          count_nxt       = '0;
          final_nxt       = 1'b0;
          state_nxt       = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      acc_r       <= '0;
      count_r     <= '0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      count_r     <= count_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dot_mod_r <= out_dot_mod_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_dot_mod = out_dot_mod_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    red_req.start |-> !red_rsp.busy && !red_rsp.done)
    else $error("remainder pass started while one is in flight");

  a_red_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RED) |-> (red_rsp.busy || red_rsp.done))
    else $error("waiting on a remainder pass that is not running");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result slot loaded outside the final state");

endmodule

// ===== rtl/modular_dot_product_core.sv =====
// Top level of the modular dot product core: config registers, front, queue, back, remainder unit.
//
//  channel   direction  handshake              payload
//  in_       request    in_valid / in_ready    in_elem_a, in_elem_b, in_last_pair
//  out_      result     out_valid / out_ready  out_dot_mod
//  config    APB write  psel penable pwrite    paddr, pwdata (prdata on read)
//
// Cycles: one pair per cycle enters the front end while the queue has room, and its
//   52-bit product is registered into a four-entry queue. The back end adds one product
//   per cycle unless it is reducing or holding a final sum. Each block boundary and each
//   last pair stalls the back end for a 64-step pass through the bit-serial remainder unit
//   and the taking of the remainder (skipped when the modulus is zero). The last pair's
//   product is registered, queued, reduced (unless the modulus is zero), then put in the result slot.
// Reset: rst_n synchronous, active low; modulus and block size come back as 1,
//   sum and block count as 0. No clearing pass.
// Stalls: the queue absorbs the front end while the back end reduces; a held
//   result does not block new pairs until the next final sum needs the slot.
module modular_dot_product_core import mdp_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input requests
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ELEM_W-1:0] in_elem_a,
  input  logic [ELEM_W-1:0] in_elem_b,
  input  logic              in_last_pair,
  // results
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  out_dot_mod,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int QW = 2 * ELEM_BITS + 1;

  // register index decoded from paddr[2]
  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_BLOCK   = 1'b1;

  logic [MOD_W-1:0] modulus_r, modulus_nxt;
  logic [BS_W-1:0]  block_size_r, block_size_nxt;
  logic             cfg_wr;

  logic             push_valid, push_ready;
  logic [QW-1:0]    push_data;
  logic             pop_valid, pop_ready;
  logic [QW-1:0]    pop_data;
  red_req_t         red_req;
  red_rsp_t         red_rsp;

  // ---------------------------------------------------------------------
  // Configuration: no wait states, write lands in the access phase
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    modulus_nxt    = modulus_r;
    block_size_nxt = block_size_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_MODULUS: modulus_nxt    = pwdata[MOD_W-1:0];
        REG_BLOCK:   block_size_nxt = pwdata[BS_W-1:0];
        default:     modulus_nxt    = modulus_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MODULUS: prdata = 32'(modulus_r);
      REG_BLOCK:   prdata = 32'(block_size_r);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r    <= MOD_W'(1);
      block_size_r <= BS_W'(1);
    end else begin
      modulus_r    <= modulus_nxt;
      block_size_r <= block_size_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Front end: accept, mask, multiply
  // ---------------------------------------------------------------------
  mdp_front #(
    .ELEM_BITS (ELEM_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_elem_a    (in_elem_a),
    .in_elem_b    (in_elem_b),
    .in_last_pair (in_last_pair),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  // ---------------------------------------------------------------------
  // Product queue: lets the front keep going during a remainder pass
  // ---------------------------------------------------------------------
  mdp_fifo #(
    .W (QW)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // ---------------------------------------------------------------------
  // Back end: accumulate, block count, sequencing, result slot
  // ---------------------------------------------------------------------
  mdp_back #(
    .ELEM_BITS (ELEM_BITS),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .modulus     (modulus_r),
    .block_size  (block_size_r),
    .red_req     (red_req),
    .red_rsp     (red_rsp),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_dot_mod (out_dot_mod)
  );

  // ---------------------------------------------------------------------
  // Remainder unit: one quotient bit per cycle over the 64-bit sum
  // ---------------------------------------------------------------------
  mdp_reduce u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .modulus (modulus_r),
    .req     (red_req),
    .rsp     (red_rsp)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the modular dot product core: stimulus, prediction, checks.
module tb;
  import mdp_pkg::*;

  // register byte addresses on the config port
  localparam logic [2:0] ADDR_MODULUS = 3'd0;
  localparam logic [2:0] ADDR_BLOCK   = 3'd4;

  localparam logic [ELEM_W-1:0] ELEM_MAX  = {ELEM_W{1'b1}};
  localparam int                QUIET_MAX = 2000;  // cycles with no handshake at all
  localparam int                SETTLE    = 100;   // covers a remainder pass
  localparam int                N_RAND    = 6;     // random phases
  localparam int                PHASE_LEN = 170;   // pairs per random phase

  // one request on the input channel
  typedef struct packed {
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    logic              last;
  } pair_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [ELEM_W-1:0] in_elem_a = '0;
  logic [ELEM_W-1:0] in_elem_b = '0;
  logic              in_last_pair = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [OUT_W-1:0]  out_dot_mod;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  modular_dot_product_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_elem_a   (in_elem_a),
    .in_elem_b   (in_elem_b),
    .in_last_pair(in_last_pair),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_dot_mod (out_dot_mod),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the registers, the running sum and the
  // count of products since the last reduction. Starts at reset values.
  // ---------------------------------------------------------------------------
  logic [MOD_W-1:0] mod_reg = MOD_W'(1);
  logic [BS_W-1:0]  bs_reg  = BS_W'(1);
  logic [ACC_W-1:0] run_sum = '0;
  logic [BS_W-1:0]  blk_cnt = '0;

  pair_t            pair_q[$];       // requests waiting for the driver
  logic [OUT_W-1:0] pending_dots[$]; // dot products the core still owes

  int sent_cnt = 0;   // requests put on the wire
  int took_cnt = 0;   // requests accepted by the core
  int n_results = 0;
  int n_cfg = 0;
  int n_err = 0;
  int quiet = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // modulus zero means no reduction at all: the sum just wraps at 64 bits
  function automatic logic [ACC_W-1:0] mod_reduce(input logic [ACC_W-1:0] v);
    if (mod_reg == '0) return v;
    return v % ACC_W'(mod_reg);
  endfunction

  // block size 0 acts as 1, anything above MAX_BLOCK_DEF saturates
  function automatic logic [BS_W-1:0] eff_block();
    if (bs_reg == '0) return BS_W'(1);
    if (bs_reg > BS_W'(MAX_BLOCK_DEF)) return BS_W'(MAX_BLOCK_DEF);
    return bs_reg;
  endfunction

  // multiply-accumulate one accepted pair; the last pair yields a dot product
  task automatic mac_pair(input pair_t p);
    logic [ACC_W-1:0] dot;
    run_sum = run_sum + (ACC_W'(p.a) * ACC_W'(p.b));
    blk_cnt = blk_cnt + BS_W'(1);
    if (p.last) begin
      dot = mod_reduce(run_sum);
      pending_dots.push_back(dot[OUT_W-1:0]);
      run_sum = '0;
      blk_cnt = '0;
    end else if (blk_cnt >= eff_block()) begin
      run_sum = mod_reduce(run_sum);
      blk_cnt = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge. Register writes,
  // accepted requests and accepted results all go through here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (psel && penable && pwrite && pready) begin
        n_cfg <= n_cfg + 1;
        if (paddr == ADDR_MODULUS) mod_reg = pwdata[MOD_W-1:0];
        else if (paddr == ADDR_BLOCK) bs_reg = pwdata[BS_W-1:0];
      end
      if (in_valid && in_ready) begin
        mac_pair('{a: in_elem_a, b: in_elem_b, last: in_last_pair});
        took_cnt <= took_cnt + 1;
      end
      if (out_valid && out_ready) begin
        n_results <= n_results + 1;
        if (pending_dots.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual dot_mod %0d",
                   $time, out_dot_mod);
          n_err <= n_err + 1;
        end else if (pending_dots[0] !== out_dot_mod) begin
          $display("%0t: dot_mod mismatch: expected %0d, actual %0d",
                   $time, pending_dots[0], out_dot_mod);
          n_err <= n_err + 1;
          void'(pending_dots.pop_front());
        end else begin
          void'(pending_dots.pop_front());
        end
      end
    end
  end

  // Watchdog: any handshake resets the count; long silence ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("%0t: timeout, %0d results still owed", $time, pending_dots.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: moves at the falling edge. A new request goes out only once the
  // current one has been taken, so valid and payload hold until accepted.
  // ---------------------------------------------------------------------------
  pair_t drv_pair;

  always @(negedge clk) begin
    if (rst_n && sent_cnt == took_cnt) begin
      if (pair_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_pair = pair_q.pop_front();
        in_elem_a    <= drv_pair.a;
        in_elem_b    <= drv_pair.b;
        in_last_pair <= drv_pair.last;
        in_valid     <= 1'b1;
        sent_cnt     <= sent_cnt + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: ready drops at random, independent of out_valid.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // APB write: setup cycle, then access cycle; pready is always high
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
                           input logic last);
    pair_q.push_back('{a: a, b: b, last: last});
  endtask

  // Sender holds back until every owed dot product is in, then lets
  // enough cycles for a remainder pass go by before touching config.
  task automatic drain();
    wait (pair_q.size() == 0 && sent_cnt == took_cnt && pending_dots.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly residues below the modulus, plus extremes and full-range values
  function automatic logic [ELEM_W-1:0] pick_elem(input logic [MOD_W-1:0] m);
    case ($urandom_range(9))
      0:       return '0;
      1:       return ELEM_MAX;
      2, 3:    return ELEM_W'($urandom());
      default: return (m == '0) ? ELEM_W'($urandom()) : ELEM_W'($urandom_range(m - 1));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [MOD_W-1:0] m;
    logic [31:0]      bsv;
    int               len;
    int               cnt;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, sender and receiver idling lightly / heavily
    send_idle_pct = 13;
    recv_idle_pct = 51;

    // reset values: modulus 1, so every dot product is zero
    push_pair(ELEM_MAX, ELEM_MAX, 1'b1);
    push_pair(26'd5, 26'd7, 1'b0);
    push_pair(26'd3, 26'd3, 1'b1);
    drain();

    // largest modulus, block size far above the saturation point
    cfg_write(ADDR_MODULUS, 32'(ELEM_MAX));
    cfg_write(ADDR_BLOCK, 32'd2047);
    push_pair(ELEM_MAX, ELEM_MAX, 1'b1);
    push_pair(ELEM_MAX - ELEM_W'(1), ELEM_MAX - ELEM_W'(1), 1'b0);
    push_pair(26'd2, 26'd3, 1'b0);
    push_pair(26'd1, 26'd1, 1'b1);
    drain();

    // modulus zero (upper write bits set, field is zero): raw low 26 bits;
    // block size zero behaves as one
    cfg_write(ADDR_MODULUS, 32'hFC00_0000);
    cfg_write(ADDR_BLOCK, 32'hFFFF_F800);
    push_pair(ELEM_MAX, ELEM_MAX, 1'b0);
    push_pair(ELEM_MAX, ELEM_MAX, 1'b1);
    push_pair(26'd0, 26'd0, 1'b1);
    push_pair(26'd12345, 26'd67890, 1'b1);
    drain();

    // elements at and above the modulus, vector crossing block boundaries
    cfg_write(ADDR_MODULUS, 32'd1000003);
    cfg_write(ADDR_BLOCK, 32'd3);
    push_pair(ELEM_MAX, 26'd1, 1'b0);
    push_pair(26'd1000003, 26'd1000003, 1'b0);
    push_pair(26'd1000002, 26'd1000002, 1'b0);
    push_pair(26'd7, 26'd9, 1'b0);
    push_pair(26'd0, ELEM_MAX, 1'b1);
    drain();

    // tiny modulus, largest legal block, alternating bit patterns
    cfg_write(ADDR_MODULUS, 32'hFC00_0002);
    cfg_write(ADDR_BLOCK, 32'(MAX_BLOCK_DEF));
    push_pair(26'd1, 26'd1, 1'b0);
    push_pair(26'd1, 26'd1, 1'b0);
    push_pair(26'd1, 26'd1, 1'b1);
    push_pair(26'h2AA_AAAA, 26'h155_5555, 1'b1);
    drain();

    // random phases: one register setting each, idling pattern by thirds
    for (int k = 0; k < N_RAND; k++) begin
      case (k)
        0:       m = ELEM_MAX;
        1:       m = MOD_W'($urandom_range(16, 1));
        2:       m = '0;
        3:       m = MOD_W'($urandom_range(32'h3FF_FFFF, 1));
        4:       m = MOD_W'(1);
        default: m = MOD_W'($urandom_range(32'h3FF_FFFF, 32'h200_0000));
      endcase
      case (k)
        0:       bsv = 32'd1;
        1:       bsv = $urandom_range(8, 2);
        2:       bsv = 32'(MAX_BLOCK_DEF);
        3:       bsv = $urandom_range(2047, MAX_BLOCK_DEF + 1);
        4:       bsv = 32'd0;
        default: bsv = $urandom_range(64, 1);
      endcase
      if (k < 2) begin
        send_idle_pct = 13;
        recv_idle_pct = 51;
      end else if (k < 4) begin
        send_idle_pct = 51;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // junk in the unused upper bits must not matter
      cfg_write(ADDR_MODULUS, {6'($urandom_range(63)), m});
      cfg_write(ADDR_BLOCK, {21'($urandom_range(32'h1F_FFFF)), bsv[BS_W-1:0]});
      cnt = 0;
      while (cnt < PHASE_LEN) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        for (int i = 0; i < len; i++) push_pair(pick_elem(m), pick_elem(m), i == len - 1);
        cnt += len;
      end
      drain();
    end

    $display("Run covered %0d pairs and %0d dot products under %0d register writes,",
             took_cnt, n_results, n_cfg);
    $display("with zero, tiny and full moduli and block sizes from zero to saturation.");
    if (n_err == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mdp_pkg.sv
rtl/mdp_front.sv
rtl/mdp_fifo.sv
rtl/mdp_reduce.sv
rtl/mdp_back.sv
rtl/modular_dot_product_core.sv
tb/tb.sv
